// ----- hdl/gpr_pkg.sv -----
package gpr_pkg;

    // Grid edge length used when the top level is not overridden
    localparam int GRID_SIZE_DEF = 9;

    // Width of every coordinate field on the input channel
    localparam int COORD_W = 4;

    // Width used for coordinate compares inside a cell (holds GRID_SIZE + 1 and more)
    localparam int CMP_W = 7;

    // Command codes of the input channel
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_FLOOD
    } gpr_state_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic               wr_en;
        logic [COORD_W-1:0] wr_row;
        logic [COORD_W-1:0] wr_col;
        logic               wr_blocked;
        logic               seed_en;
        logic [COORD_W-1:0] src_row;
        logic [COORD_W-1:0] src_col;
        logic               flood_en;
        logic [COORD_W-1:0] dst_row;
        logic [COORD_W-1:0] dst_col;
    } gpr_ctrl_t;

    // Status of one cell or of one row
    typedef struct packed {
        logic grew;
        logic hit;
    } gpr_stat_t;

endpackage

// ----- hdl/gpr_cell.sv -----
module gpr_cell
    import gpr_pkg::*;
#(
    parameter int ROW = 0,
    parameter int COL = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  gpr_ctrl_t ctrl,
    input  logic      north_reached,
    input  logic      south_reached,
    input  logic      west_reached,
    input  logic      east_reached,
    output logic      reached,
    output gpr_stat_t stat
);

    localparam logic [CMP_W-1:0] ROW_C = CMP_W'(ROW);
    localparam logic [CMP_W-1:0] COL_C = CMP_W'(COL);
    localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1);

    logic             obstacle_reg;
    logic             obstacle_next;
    logic             reached_reg;
    logic             reached_next;
    logic [CMP_W-1:0] src_r;
    logic [CMP_W-1:0] src_c;
    logic             wr_hit;
    logic             is_seed;
    logic             is_dst;

    assign src_r = CMP_W'(ctrl.src_row);
    assign src_c = CMP_W'(ctrl.src_col);

    assign wr_hit = ctrl.wr_en && (CMP_W'(ctrl.wr_row) == ROW_C)
                    && (CMP_W'(ctrl.wr_col) == COL_C);

    // A seed sits one step away from the source, in any of the four directions
    assign is_seed = ((src_r == ROW_C) && ((src_c == COL_C + ONE_C) || (src_c + ONE_C == COL_C)))
                  || ((src_c == COL_C) && ((src_r == ROW_C + ONE_C) || (src_r + ONE_C == ROW_C)));

    assign is_dst = (CMP_W'(ctrl.dst_row) == ROW_C) && (CMP_W'(ctrl.dst_col) == COL_C);

    // Update the blocked mark on a matching write
    always_comb begin
        obstacle_next = obstacle_reg;
        if (wr_hit) begin
            obstacle_next = ctrl.wr_blocked;
        end
    end

    // Seed on a new query, then grow from any reached neighbor
    always_comb begin
        reached_next = reached_reg;
        if (ctrl.seed_en) begin
            reached_next = is_seed && !obstacle_reg;
        end else if (ctrl.flood_en) begin
            reached_next = reached_reg || (!obstacle_reg && (north_reached || south_reached
                           || west_reached || east_reached));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obstacle_reg <= 1'b0;
            reached_reg  <= 1'b0;
        end else begin
            obstacle_reg <= obstacle_next;
            reached_reg  <= reached_next;
        end
    end

    assign reached   = reached_reg;
    assign stat.grew = ctrl.flood_en && reached_next && !reached_reg;
    assign stat.hit  = reached_reg && is_dst;

endmodule

// ----- hdl/gpr_row.sv -----
module gpr_row
    import gpr_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF,
    parameter int ROW       = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gpr_ctrl_t            ctrl,
    input  logic [GRID_SIZE-1:0] up_reached,
    input  logic [GRID_SIZE-1:0] dn_reached,
    output logic [GRID_SIZE-1:0] row_reached,
    output gpr_stat_t            row_stat
);

    logic [GRID_SIZE-1:0] grew_vec;
    logic [GRID_SIZE-1:0] hit_vec;
    gpr_stat_t            stat_reg;
    gpr_stat_t            stat_next;

    for (genvar c = 0; c < GRID_SIZE; c++) begin : g_cell
        logic      west_in;
        logic      east_in;
        gpr_stat_t cell_stat;

        if (c == 0) begin : g_west_edge
            assign west_in = 1'b0;
        end else begin : g_west
            assign west_in = row_reached[c-1];
        end

        if (c == GRID_SIZE - 1) begin : g_east_edge
            assign east_in = 1'b0;
        end else begin : g_east
            assign east_in = row_reached[c+1];
        end

        gpr_cell #(
            .ROW (ROW),
            .COL (c)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (ctrl),
            .north_reached (up_reached[c]),
            .south_reached (dn_reached[c]),
            .west_reached  (west_in),
            .east_reached  (east_in),
            .reached       (row_reached[c]),
            .stat          (cell_stat)
        );

        assign grew_vec[c] = cell_stat.grew;
        assign hit_vec[c]  = cell_stat.hit;
    end

    // Reduce the row's cell status and register it
    assign stat_next.grew = |grew_vec;
    assign stat_next.hit  = |hit_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_reg <= '0;
        end else begin
            stat_reg <= stat_next;
        end
    end

    assign row_stat = stat_reg;

endmodule

// ----- hdl/grid_path_reachability.sv -----
// Channel | Ports                                                  | Transfer
// input   | s_valid s_ready s_cmd s_cell_row s_cell_col s_blocked  | s_valid && s_ready
//         | s_src_row s_src_col s_dst_row s_dst_col                |
// result  | m_valid m_ready m_path_found                           | m_valid && m_ready
//
// A write leaves no result; the next item may follow at once.
// A query floods the cell array one wavefront step at a time, checked through the
// registered row status; it ends when the wavefront stops growing, or early once the
// destination is reached. Source equal to destination finishes without waiting on the flood.
// Reset (aresetn low, synchronous) marks every cell passable and empties the output.
// A finished query waits in the flood state while the result register is still full.
module grid_path_reachability
    import gpr_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [COORD_W-1:0] s_cell_row,
    input  logic [COORD_W-1:0] s_cell_col,
    input  logic               s_blocked,
    input  logic [COORD_W-1:0] s_src_row,
    input  logic [COORD_W-1:0] s_src_col,
    input  logic [COORD_W-1:0] s_dst_row,
    input  logic [COORD_W-1:0] s_dst_col,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_path_found
);

    gpr_state_t         state_reg;
    gpr_state_t         state_next;
    logic               first_reg;
    logic               first_next;
    logic               same_reg;
    logic               same_next;
    logic [COORD_W-1:0] dst_row_reg;
    logic [COORD_W-1:0] dst_row_next;
    logic [COORD_W-1:0] dst_col_reg;
    logic [COORD_W-1:0] dst_col_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic               m_path_found_reg;
    logic               m_path_found_next;

    logic               accept;
    logic               flood_done;
    logic               out_free;
    logic               any_grew;
    logic               any_hit;
    gpr_ctrl_t          ctrl;

    logic [GRID_SIZE-1:0] row_reached [GRID_SIZE];
    gpr_stat_t            row_stat    [GRID_SIZE];

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Broadcast write, seed and flood controls to the cell array
    always_comb begin
        ctrl.wr_en      = accept && (s_cmd == CMD_WRITE);
        ctrl.wr_row     = s_cell_row;
        ctrl.wr_col     = s_cell_col;
        ctrl.wr_blocked = s_blocked;
        ctrl.seed_en    = accept && (s_cmd == CMD_QUERY);
        ctrl.src_row    = s_src_row;
        ctrl.src_col    = s_src_col;
        ctrl.flood_en   = (state_reg == ST_FLOOD);
        ctrl.dst_row    = dst_row_reg;
        ctrl.dst_col    = dst_col_reg;
    end

    for (genvar r = 0; r < GRID_SIZE; r++) begin : g_row
        logic [GRID_SIZE-1:0] up_in;
        logic [GRID_SIZE-1:0] dn_in;

        if (r == 0) begin : g_top_edge
            assign up_in = '0;
        end else begin : g_up
            assign up_in = row_reached[r-1];
        end

        if (r == GRID_SIZE - 1) begin : g_bottom_edge
            assign dn_in = '0;
        end else begin : g_dn
            assign dn_in = row_reached[r+1];
        end

        gpr_row #(
            .GRID_SIZE (GRID_SIZE),
            .ROW       (r)
        ) u_row (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .up_reached  (up_in),
            .dn_reached  (dn_in),
            .row_reached (row_reached[r]),
            .row_stat    (row_stat[r])
        );
    end

    // Combine the registered row status
    always_comb begin
        any_grew = 1'b0;
        any_hit  = 1'b0;
        for (int r = 0; r < GRID_SIZE; r++) begin
            any_grew = any_grew | row_stat[r].grew;
            any_hit  = any_hit | row_stat[r].hit;
        end
    end

    assign flood_done = same_reg || (!first_reg && (any_hit || !any_grew));
    assign out_free   = !m_valid_reg || m_ready;

    // Next state and result register load
    always_comb begin
        state_next        = state_reg;
        first_next        = first_reg;
        same_next         = same_reg;
        dst_row_next      = dst_row_reg;
        dst_col_next      = dst_col_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_path_found_next = m_path_found_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.seed_en) begin
                    state_next   = ST_FLOOD;
                    first_next   = 1'b1;
                    same_next    = (s_src_row == s_dst_row) && (s_src_col == s_dst_col);
                    dst_row_next = s_dst_row;
                    dst_col_next = s_dst_col;
                end
            end
            ST_FLOOD: begin
                first_next = 1'b0;
                if (flood_done && out_free) begin
                    m_valid_next      = 1'b1;
                    m_path_found_next = same_reg || any_hit;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            first_reg   <= 1'b0;
            same_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            first_reg   <= first_next;
            same_reg    <= same_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold query coordinates and result payload
    always_ff @(posedge aclk) begin
        dst_row_reg      <= dst_row_next;
        dst_col_reg      <= dst_col_next;
        m_path_found_reg <= m_path_found_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_path_found = m_path_found_reg;

`ifndef SYNTH
    // A query transfer always starts a flood
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == CMD_QUERY) |=> (state_reg == ST_FLOOD))
        else $error("query transfer did not start a flood");

    // A new result only comes out of a flood
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FLOOD))
        else $error("result raised outside a flood");

    // The first flood cycle never ends a query with a different destination
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLOOD && first_reg && !same_reg) |=> (state_reg == ST_FLOOD))
        else $error("flood ended on stale row status");

    // A query of a cell against itself always reports a path
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLOOD && same_reg && out_free) |=> (m_valid && m_path_found))
        else $error("same-cell query did not report a path");
`endif

endmodule

// ----- tb/tb_grid_path_reachability.sv -----
`timescale 1ns / 1ps

module tb_grid_path_reachability;
    import gpr_pkg::*;

    localparam int GRID = GRID_SIZE_DEF;

    typedef struct {
        logic               cmd;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               blocked;
        logic [COORD_W-1:0] src_row;
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] dst_row;
        logic [COORD_W-1:0] dst_col;
    } grid_item_t;

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic               s_cmd        = CMD_WRITE;
    logic [COORD_W-1:0] s_cell_row   = '0;
    logic [COORD_W-1:0] s_cell_col   = '0;
    logic               s_blocked    = 1'b0;
    logic [COORD_W-1:0] s_src_row    = '0;
    logic [COORD_W-1:0] s_src_col    = '0;
    logic [COORD_W-1:0] s_dst_row    = '0;
    logic [COORD_W-1:0] s_dst_col    = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic               m_path_found;

    // Pending input items and results still owed by the block
    grid_item_t send_queue[$];
    grid_item_t cur_item;
    logic       path_expected[$];
    logic       path_want;

    // Shadow copy of the obstacle map
    bit wall_map[GRID][GRID];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int queued_count   = 0;
    int accepted_count = 0;
    int write_count    = 0;
    int query_count    = 0;
    int reach_count    = 0;
    int result_count   = 0;
    int fail_count     = 0;

    grid_path_reachability #(
        .GRID_SIZE(GRID)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_cell_row  (s_cell_row),
        .s_cell_col  (s_cell_col),
        .s_blocked   (s_blocked),
        .s_src_row   (s_src_row),
        .s_src_col   (s_src_col),
        .s_dst_row   (s_dst_row),
        .s_dst_col   (s_dst_col),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_path_found(m_path_found)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Flood the free cells from the source's neighbors and report whether the
    // destination got marked; source equal to destination always succeeds
    function automatic bit flood_reachable(int sr, int sc, int dr, int dc);
        bit reached[GRID][GRID];
        bit grew;
        int nr;
        int nc;
        if (sr == dr && sc == dc) return 1'b1;
        for (int r = 0; r < GRID; r++)
            for (int c = 0; c < GRID; c++)
                reached[r][c] = 1'b0;
        for (int k = 0; k < 4; k++) begin
            nr = sr + (k == 0) - (k == 1);
            nc = sc + (k == 2) - (k == 3);
            if (nr >= 0 && nr < GRID && nc >= 0 && nc < GRID && !wall_map[nr][nc])
                reached[nr][nc] = 1'b1;
        end
        do begin
            grew = 1'b0;
            for (int r = 0; r < GRID; r++) begin
                for (int c = 0; c < GRID; c++) begin
                    if (!reached[r][c] && !wall_map[r][c] &&
                        ((r > 0 && reached[r-1][c]) || (r < GRID-1 && reached[r+1][c]) ||
                         (c > 0 && reached[r][c-1]) || (c < GRID-1 && reached[r][c+1]))) begin
                        reached[r][c] = 1'b1;
                        grew = 1'b1;
                    end
                end
            end
        end while (grew);
        if (dr >= GRID || dc >= GRID) return 1'b0;
        return reached[dr][dc];
    endfunction

    // Queue a cell write; the query fields carry noise
    task automatic push_write(int r, int c, bit blk);
        grid_item_t it;
        it.cmd      = CMD_WRITE;
        it.cell_row = COORD_W'(r);
        it.cell_col = COORD_W'(c);
        it.blocked  = blk;
        it.src_row  = COORD_W'($urandom_range(15));
        it.src_col  = COORD_W'($urandom_range(15));
        it.dst_row  = COORD_W'($urandom_range(15));
        it.dst_col  = COORD_W'($urandom_range(15));
        send_queue.insert(send_queue.size(), it);
        queued_count++;
    endtask

    // Queue a path query; the write fields carry noise
    task automatic push_query(int sr, int sc, int dr, int dc);
        grid_item_t it;
        it.cmd      = CMD_QUERY;
        it.cell_row = COORD_W'($urandom_range(15));
        it.cell_col = COORD_W'($urandom_range(15));
        it.blocked  = 1'($urandom_range(1));
        it.src_row  = COORD_W'(sr);
        it.src_col  = COORD_W'(sc);
        it.dst_row  = COORD_W'(dr);
        it.dst_col  = COORD_W'(dc);
        send_queue.insert(send_queue.size(), it);
        queued_count++;
    endtask

    // Mostly in-grid coordinates, sometimes anywhere in the 4-bit range
    function automatic int rand_coord();
        if ($urandom_range(99) < 85) return $urandom_range(GRID - 1);
        return $urandom_range(15);
    endfunction

    // Hold until every item is taken and every result has come back
    task automatic drain_all();
        while (accepted_count != queued_count || path_expected.size() != 0)
            @(posedge aclk);
    endtask

    // Driver: on a transfer update the shadow map or predict the answer,
    // then present the next pending item or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                accepted_count++;
                if (cur_item.cmd == CMD_WRITE) begin
                    write_count++;
                    if (cur_item.cell_row < GRID && cur_item.cell_col < GRID)
                        wall_map[cur_item.cell_row][cur_item.cell_col] = cur_item.blocked;
                end else begin
                    query_count++;
                    path_expected.insert(path_expected.size(),
                                         flood_reachable(cur_item.src_row, cur_item.src_col,
                                                         cur_item.dst_row, cur_item.dst_col));
                end
            end
            if (!s_valid || s_ready) begin
                if (send_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = send_queue.pop_front();
                    s_valid    <= 1'b1;
                    s_cmd      <= cur_item.cmd;
                    s_cell_row <= cur_item.cell_row;
                    s_cell_col <= cur_item.cell_col;
                    s_blocked  <= cur_item.blocked;
                    s_src_row  <= cur_item.src_row;
                    s_src_col  <= cur_item.src_col;
                    s_dst_row  <= cur_item.dst_row;
                    s_dst_col  <= cur_item.dst_col;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (path_expected.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] unexpected result path_found=%b", $realtime, m_path_found);
            end else begin
                path_want = path_expected.pop_front();
                if (path_want) reach_count++;
                if (m_path_found !== path_want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] path_found mismatch: expected %b, got %b",
                                 $realtime, path_want, m_path_found);
                end
            end
        end
    end

    // Stimulus: directed corners first, then random maps under four idle patterns
    initial begin
        int send_pct[4];
        int stall_pct[4];
        int density_pct[5];
        int blk_pct;
        int sr;
        int sc;

        send_pct    = '{0, 62, 0, 20};
        stall_pct   = '{0, 0, 62, 20};
        density_pct = '{5, 25, 40, 55, 75};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty map: trivial, corner-to-corner and off-grid endpoints
        push_query(0, 0, 0, 0);
        push_query(15, 15, 15, 15);
        push_query(0, 0, 8, 8);
        push_query(0, 0, 9, 0);
        push_query(9, 4, 0, 0);
        push_query(15, 15, 0, 0);
        // Blocked destination, then blocked source
        push_write(8, 8, 1'b1);
        push_query(0, 0, 8, 8);
        push_query(8, 8, 0, 0);
        // Off-grid writes leave the map alone
        push_write(9, 2, 1'b1);
        push_write(15, 15, 1'b1);
        push_query(0, 0, 8, 0);
        // Wall in the corner cell
        push_write(0, 1, 1'b1);
        push_write(1, 0, 1'b1);
        push_query(0, 0, 0, 2);
        push_query(0, 0, 1, 0);
        push_query(0, 1, 0, 0);
        // Clear everything again
        push_write(0, 1, 1'b0);
        push_write(1, 0, 1'b0);
        push_write(8, 8, 1'b0);
        push_query(8, 0, 0, 8);
        drain_all();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = stall_pct[ph];
            blk_pct = density_pct[0];
            for (int n = 0; n < 450; n++) begin
                // Move the map toward a new obstacle density now and then
                if (n % 50 == 0) blk_pct = density_pct[$urandom_range(4)];
                if ($urandom_range(1) == 0) begin
                    push_write(rand_coord(), rand_coord(), $urandom_range(99) < blk_pct);
                end else begin
                    sr = rand_coord();
                    sc = rand_coord();
                    if ($urandom_range(19) == 0)
                        push_query(sr, sc, sr, sc);
                    else
                        push_query(sr, sc, rand_coord(), rand_coord());
                end
            end
            // Let the block run dry before the idle pattern changes
            drain_all();
        end

        repeat (100) @(posedge aclk);
        $display("Run covered %0d writes and %0d queries, %0d results (%0d reachable).",
                 write_count, query_count, result_count, reach_count);
        $display("Idle patterns: none, sender 62%%, receiver 62%%, both 20%%; failures: %0d.",
                 fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout: %0d of %0d items taken, %0d results outstanding.",
                 accepted_count, queued_count, path_expected.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/gpr_pkg.sv
hdl/gpr_cell.sv
hdl/gpr_row.sv
hdl/grid_path_reachability.sv
tb/tb_grid_path_reachability.sv
